/* hw/rtl/rci_pkg.sv */
// rci_pkg: shared types and constants for the ray / circle intersection block
// no dependencies
package rci_pkg;

  localparam int RADIUS_WIDTH = 15;
  localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 15'd256;

  // per-stage control that travels along the cell chains
  typedef struct packed {
    logic valid;
  } ctl_t;

endpackage

/* hw/rtl/rci_sqrt_cell.sv */
// rci_sqrt_cell: one restoring square root step, one result bit per cell
// depends on rci_pkg
module rci_sqrt_cell #(
  parameter int SW  = 31,
  parameter int SBW = 130
) (
  input  logic                clk,
  input  logic                rst,
  input  rci_pkg::ctl_t       ctl_in,
  input  logic [2*SW-1:0]     rad_in,
  input  logic [SW:0]         rem_in,
  input  logic [SW-1:0]       root_in,
  input  logic [SBW-1:0]      side_in,
  output rci_pkg::ctl_t       ctl_out,
  output logic [2*SW-1:0]     rad_out,
  output logic [SW:0]         rem_out,
  output logic [SW-1:0]       root_out,
  output logic [SBW-1:0]      side_out
);

  logic [SW+2:0] partial;
  logic [SW+2:0] trial;
  logic          take;
  logic [SW+2:0] diff;

  always_comb begin
    partial = {rem_in, rad_in[2*SW-1:2*SW-2]};
    trial   = {1'b0, root_in, 2'b01};
    take    = partial >= trial;
    diff    = partial - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    rad_out  <= {rad_in[2*SW-3:0], 2'b00};
    rem_out  <= take ? diff[SW:0] : partial[SW:0];
    root_out <= {root_in[SW-2:0], take};
    side_out <= side_in;
  end

endmodule

/* hw/rtl/rci_div_cell.sv */
// rci_div_cell: one restoring division step for two numerators over a shared divisor
// depends on rci_pkg
module rci_div_cell #(
  parameter int DENW = 32,
  parameter int PW   = 50,
  parameter int SBW  = 35
) (
  input  logic             clk,
  input  logic             rst,
  input  rci_pkg::ctl_t    ctl_in,
  input  logic [DENW-1:0]  den_in,
  input  logic [PW-1:0]    num_x_in,
  input  logic [PW-1:0]    num_y_in,
  input  logic [DENW-1:0]  rem_x_in,
  input  logic [DENW-1:0]  rem_y_in,
  input  logic [SBW-1:0]   side_in,
  output rci_pkg::ctl_t    ctl_out,
  output logic [DENW-1:0]  den_out,
  output logic [PW-1:0]    num_x_out,
  output logic [PW-1:0]    num_y_out,
  output logic [DENW-1:0]  rem_x_out,
  output logic [DENW-1:0]  rem_y_out,
  output logic [SBW-1:0]   side_out
);

  logic [DENW:0] part_x, part_y, diff_x, diff_y;
  logic          ge_x, ge_y;

  always_comb begin
    part_x = {rem_x_in, num_x_in[PW-1]};
    part_y = {rem_y_in, num_y_in[PW-1]};
    ge_x   = part_x >= {1'b0, den_in};
    ge_y   = part_y >= {1'b0, den_in};
    diff_x = part_x - {1'b0, den_in};
    diff_y = part_y - {1'b0, den_in};
  end

  // numerator shifts out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    den_out   <= den_in;
    rem_x_out <= ge_x ? diff_x[DENW-1:0] : part_x[DENW-1:0];
    rem_y_out <= ge_y ? diff_y[DENW-1:0] : part_y[DENW-1:0];
    num_x_out <= {num_x_in[PW-2:0], ge_x};
    num_y_out <= {num_y_in[PW-2:0], ge_y};
    side_out  <= side_in;
  end

endmodule

/* hw/rtl/ray_circle_intersection.sv */
// ray_circle_intersection: 2d ray against origin-centred circle, fixed point
// depends on rci_pkg, rci_sqrt_cell, rci_div_cell
// pipeline of product, discriminant and numerator stages around two cell chains:
// the sqrt chain has one cell per root bit, the divider chain one per quotient bit
// throughput one request per cycle, busy stays low; the receiver cannot stall
// reset clears stage valids and sets the radius to 1.0
module ray_circle_intersection #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [COORD_WIDTH-1:0]         origin_x,
  input  logic signed [COORD_WIDTH-1:0]         origin_y,
  input  logic signed [COORD_WIDTH-1:0]         dir_x,
  input  logic signed [COORD_WIDTH-1:0]         dir_y,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rci_pkg::RADIUS_WIDTH-1:0]      cfg_data,
  output logic                                  done,
  output logic                                  hit_valid,
  output logic signed [COORD_WIDTH-1:0]         hit_x,
  output logic signed [COORD_WIDTH-1:0]         hit_y,
  output logic                                  clipped
);

  localparam int W   = COORD_WIDTH + FRAC_BITS - FRAC_BITS;
  localparam int RW  = rci_pkg::RADIUS_WIDTH;
  localparam int QW  = 2*W + 2*RW;
  localparam int SW  = W + RW;
  localparam int DW  = ((2*W + 2*RW > 4*W) ? 2*W + 2*RW : 4*W) + 1;
  localparam int NW  = ((2*W + 1 > SW + 1) ? 2*W + 1 : SW + 1) + 1;
  localparam int PW  = NW + W;
  localparam int SB1 = 8*W + 2;
  localparam int SB2 = 2*W + 3;

  // radius register
  logic [RW-1:0]   radius;
  logic [2*RW-1:0] r_sq;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= rci_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
    r_sq <= radius * radius;
  end

  // stage 1: products
  logic                  s1_v, s1_dz;
  logic signed [W-1:0]   s1_ox, s1_oy, s1_dx, s1_dy;
  logic signed [2*W-1:0] s1_xx, s1_yy, s1_xo, s1_yo, s1_xoy, s1_yox;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start && !busy;
    end
    s1_dz  <= (dir_x == '0) && (dir_y == '0);
    s1_ox  <= origin_x;
    s1_oy  <= origin_y;
    s1_dx  <= dir_x;
    s1_dy  <= dir_y;
    s1_xx  <= dir_x * dir_x;
    s1_yy  <= dir_y * dir_y;
    s1_xo  <= dir_x * origin_x;
    s1_yo  <= dir_y * origin_y;
    s1_xoy <= dir_x * origin_y;
    s1_yox <= dir_y * origin_x;
  end

  // stage 2: a = |d|^2, h = d.o, cross = d x o
  logic                  s2_v, s2_dz;
  logic signed [W-1:0]   s2_ox, s2_oy, s2_dx, s2_dy;
  logic [2*W-1:0]        s2_a;
  logic signed [2*W:0]   s2_h, s2_cross;
  logic [2*W:0]          a_sum;

  assign a_sum = {1'b0, s1_xx} + {1'b0, s1_yy};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_dz    <= s1_dz;
    s2_ox    <= s1_ox;
    s2_oy    <= s1_oy;
    s2_dx    <= s1_dx;
    s2_dy    <= s1_dy;
    s2_a     <= a_sum[2*W-1:0];
    s2_h     <= {s1_xo[2*W-1], s1_xo} + {s1_yo[2*W-1], s1_yo};
    s2_cross <= {s1_xoy[2*W-1], s1_xoy} - {s1_yox[2*W-1], s1_yox};
  end

  // stage 3: a r^2 and cross^2, for disc = a r^2 - cross^2, equal to h^2 - a c
  logic                  s3_v, s3_dz;
  logic signed [W-1:0]   s3_ox, s3_oy, s3_dx, s3_dy;
  logic [2*W-1:0]        s3_a;
  logic signed [2*W:0]   s3_h;
  logic [2*W+2*RW-1:0]   s3_ar;
  logic [4*W-1:0]        s3_cc;
  logic [2*W:0]          cross_abs_w;
  logic [2*W-1:0]        cross_abs;

  assign cross_abs_w = s2_cross[2*W] ? -s2_cross : s2_cross;
  assign cross_abs   = cross_abs_w[2*W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_dz <= s2_dz;
    s3_ox <= s2_ox;
    s3_oy <= s2_oy;
    s3_dx <= s2_dx;
    s3_dy <= s2_dy;
    s3_a  <= s2_a;
    s3_h  <= s2_h;
    s3_ar <= s2_a * r_sq;
    s3_cc <= cross_abs * cross_abs;
  end

  // stage 4
  logic                  s4_v, s4_hit;
  logic signed [W-1:0]   s4_ox, s4_oy, s4_dx, s4_dy;
  logic [2*W-1:0]        s4_a;
  logic signed [2*W:0]   s4_h;
  logic [DW-1:0]         disc;
  logic [QW-1:0]         s4_rad;

  assign disc = DW'(s3_ar) - DW'(s3_cc);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= s3_v;
    end
    s4_hit <= !s3_dz && !disc[DW-1];
    s4_rad <= (!s3_dz && !disc[DW-1]) ? disc[QW-1:0] : '0;
    s4_ox  <= s3_ox;
    s4_oy  <= s3_oy;
    s4_dx  <= s3_dx;
    s4_dy  <= s3_dy;
    s4_a   <= s3_a;
    s4_h   <= s3_h;
  end

  // square root chain
  rci_pkg::ctl_t  sq_ctl  [SW+1];
  logic [QW-1:0]  sq_rad  [SW+1];
  logic [SW:0]    sq_rem  [SW+1];
  logic [SW-1:0]  sq_root [SW+1];
  logic [SB1-1:0] sq_side [SW+1];

  assign sq_ctl[0].valid = s4_v;
  assign sq_rad[0]       = s4_rad;
  assign sq_rem[0]       = '0;
  assign sq_root[0]      = '0;
  assign sq_side[0]      = {s4_hit, s4_a, s4_h, s4_ox, s4_oy, s4_dx, s4_dy};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    rci_sqrt_cell #(.SW(SW), .SBW(SB1)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (sq_ctl[i]),
      .rad_in   (sq_rad[i]),
      .rem_in   (sq_rem[i]),
      .root_in  (sq_root[i]),
      .side_in  (sq_side[i]),
      .ctl_out  (sq_ctl[i+1]),
      .rad_out  (sq_rad[i+1]),
      .rem_out  (sq_rem[i+1]),
      .root_out (sq_root[i+1]),
      .side_out (sq_side[i+1])
    );
  end

  logic                  q_hit;
  logic [2*W-1:0]        q_a;
  logic signed [2*W:0]   q_h;
  logic signed [W-1:0]   q_ox, q_oy, q_dx, q_dy;

  assign {q_hit, q_a, q_h, q_ox, q_oy, q_dx, q_dy} = sq_side[SW];

  // stage 5: num = -h - s
  logic                  s5_v, s5_hit;
  logic signed [W-1:0]   s5_ox, s5_oy, s5_dx, s5_dy;
  logic [2*W-1:0]        s5_a;
  logic signed [NW-1:0]  s5_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else begin
      s5_v <= sq_ctl[SW].valid;
    end
    s5_hit <= q_hit;
    s5_ox  <= q_ox;
    s5_oy  <= q_oy;
    s5_dx  <= q_dx;
    s5_dy  <= q_dy;
    s5_a   <= q_a;
    s5_num <= -NW'(q_h) - NW'({1'b0, sq_root[SW]});
  end

  // stage 6: num * d
  logic                  s6_v, s6_hit;
  logic signed [W-1:0]   s6_ox, s6_oy;
  logic [2*W-1:0]        s6_a;
  logic signed [PW-1:0]  s6_px, s6_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else begin
      s6_v <= s5_v;
    end
    s6_hit <= s5_hit;
    s6_ox  <= s5_ox;
    s6_oy  <= s5_oy;
    // a nonzero divisor keeps the divider sane on misses
    s6_a   <= s5_hit ? s5_a : {{(2*W-1){1'b0}}, 1'b1};
    s6_px  <= s5_num * s5_dx;
    s6_py  <= s5_num * s5_dy;
  end

  // divider chain on magnitudes, truncation toward zero
  rci_pkg::ctl_t   dv_ctl  [PW+1];
  logic [2*W-1:0]  dv_den  [PW+1];
  logic [PW-1:0]   dv_nx   [PW+1];
  logic [PW-1:0]   dv_ny   [PW+1];
  logic [2*W-1:0]  dv_rx   [PW+1];
  logic [2*W-1:0]  dv_ry   [PW+1];
  logic [SB2-1:0]  dv_side [PW+1];

  assign dv_ctl[0].valid = s6_v;
  assign dv_den[0]       = s6_a;
  assign dv_nx[0]        = s6_px[PW-1] ? -s6_px : s6_px;
  assign dv_ny[0]        = s6_py[PW-1] ? -s6_py : s6_py;
  assign dv_rx[0]        = '0;
  assign dv_ry[0]        = '0;
  assign dv_side[0]      = {s6_hit, s6_px[PW-1], s6_py[PW-1], s6_ox, s6_oy};

  for (genvar j = 0; j < PW; j++) begin : g_div
    rci_div_cell #(.DENW(2*W), .PW(PW), .SBW(SB2)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl_in    (dv_ctl[j]),
      .den_in    (dv_den[j]),
      .num_x_in  (dv_nx[j]),
      .num_y_in  (dv_ny[j]),
      .rem_x_in  (dv_rx[j]),
      .rem_y_in  (dv_ry[j]),
      .side_in   (dv_side[j]),
      .ctl_out   (dv_ctl[j+1]),
      .den_out   (dv_den[j+1]),
      .num_x_out (dv_nx[j+1]),
      .num_y_out (dv_ny[j+1]),
      .rem_x_out (dv_rx[j+1]),
      .rem_y_out (dv_ry[j+1]),
      .side_out  (dv_side[j+1])
    );
  end

  logic                  f_hit, f_sx, f_sy;
  logic signed [W-1:0]   f_ox, f_oy;
  logic [PW:0]           qx_s, qy_s;
  logic [PW+1:0]         sum_x, sum_y;
  logic                  clip_x, clip_y;
  logic [W-1:0]          sat_x, sat_y;

  assign {f_hit, f_sx, f_sy, f_ox, f_oy} = dv_side[PW];

  always_comb begin
    qx_s   = f_sx ? -{1'b0, dv_nx[PW]} : {1'b0, dv_nx[PW]};
    qy_s   = f_sy ? -{1'b0, dv_ny[PW]} : {1'b0, dv_ny[PW]};
    sum_x  = (PW+2)'(f_ox) + {qx_s[PW], qx_s};
    sum_y  = (PW+2)'(f_oy) + {qy_s[PW], qy_s};
    // out of range when the bits above the sign are not all copies of it
    clip_x = (sum_x[PW+1:W-1] != '0) && (sum_x[PW+1:W-1] != '1);
    clip_y = (sum_y[PW+1:W-1] != '0) && (sum_y[PW+1:W-1] != '1);
    sat_x  = clip_x ? {sum_x[PW+1], {(W-1){!sum_x[PW+1]}}} : sum_x[W-1:0];
    sat_y  = clip_y ? {sum_y[PW+1], {(W-1){!sum_y[PW+1]}}} : sum_y[W-1:0];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_ctl[PW].valid;
    end
    hit_valid <= f_hit;
    hit_x     <= f_hit ? sat_x : '0;
    hit_y     <= f_hit ? sat_y : '0;
    clipped   <= f_hit && (clip_x || clip_y);
  end

endmodule
